### rtl/htlv_pkg.sv
// Package for the hex-text TLV tag field parser: parser state and result types,
// the hex digit decoder, the known-tag lookup and the field capacity table.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package htlv_pkg;

    // Sizes of the result fields and of the tag list.
    localparam int NumTags  = 29;
    localparam int FieldW   = 5;
    localparam int OffsetW  = 9;
    localparam int CharW    = 8;
    localparam int TagW     = 16;
    localparam int LengthW  = 8;
    localparam int CapW     = 8;

    // Result status codes.
    localparam logic ST_VALUE  = 1'b0;
    localparam logic ST_BADHEX = 1'b1;

    // Uppercase 'F' as the second tag character selects a four-character tag.
    localparam logic [CharW-1:0] CharUpperF = 8'h46;

    // Tag lengths in characters.
    localparam logic [2:0] TagDigitsShort = 3'd2;
    localparam logic [2:0] TagDigitsLong  = 3'd4;

    // Number of characters in the length header.
    localparam logic [2:0] LengthDigits = 3'd2;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [1:0]           digit_count;
        logic [2:0]           tag_digits;
        logic [TagW-1:0]      tag_value;
        logic [LengthW-1:0]   length_value;
        logic [OffsetW-1:0]   chars_left;
        logic [FieldW-1:0]    current_field;
        logic                 field_known;
        logic [OffsetW-1:0]   char_offset;
        logic                 halted;
    } parse_state_t;

    localparam parse_state_t StateReset = '{
        phase:         PH_TAG,
        digit_count:   2'd0,
        tag_digits:    TagDigitsShort,
        tag_value:     '0,
        length_value:  '0,
        chars_left:    '0,
        current_field: '0,
        field_known:   1'b0,
        char_offset:   '0,
        halted:        1'b0
    };

    typedef struct packed {
        logic                 status;
        logic [FieldW-1:0]    field_id;
        logic [OffsetW-1:0]   value_offset;
        logic [CharW-1:0]     value_char;
        logic                 last_char;
        logic                 fits_field;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    typedef struct packed {
        logic              known;
        logic [FieldW-1:0] idx;
    } tag_match_t;

    // Decode one ASCII hex digit; both letter cases are accepted.
    function automatic hex_t hex_decode(input logic [CharW-1:0] c);
        hex_t h;
        h.ok  = 1'b0;
        h.val = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok = 1'b1;
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.ok  = 1'b1;
            h.val = 4'(c[3:0] + 4'd9);
        end
        return h;
    endfunction

    // Match a completed tag against the known tag list.
    function automatic tag_match_t tag_lookup(input logic [TagW-1:0] tag);
        tag_match_t m;
        m.known = 1'b1;
        unique case (tag)
            16'h0071: m.idx = 5'd0;
            16'h0072: m.idx = 5'd1;
            16'h0082: m.idx = 5'd2;
            16'h0084: m.idx = 5'd3;
            16'h0091: m.idx = 5'd4;
            16'h0095: m.idx = 5'd5;
            16'h009A: m.idx = 5'd6;
            16'h009C: m.idx = 5'd7;
            16'h5F2A: m.idx = 5'd8;
            16'h9F02: m.idx = 5'd9;
            16'h9F03: m.idx = 5'd10;
            16'h9F06: m.idx = 5'd11;
            16'h9F07: m.idx = 5'd12;
            16'h9F09: m.idx = 5'd13;
            16'h9F10: m.idx = 5'd14;
            16'h9F1A: m.idx = 5'd15;
            16'h9F1E: m.idx = 5'd16;
            16'h9F26: m.idx = 5'd17;
            16'h9F27: m.idx = 5'd18;
            16'h9F33: m.idx = 5'd19;
            16'h9F34: m.idx = 5'd20;
            16'h9F35: m.idx = 5'd21;
            16'h9F36: m.idx = 5'd22;
            16'h9F37: m.idx = 5'd23;
            16'h9F41: m.idx = 5'd24;
            16'h9F53: m.idx = 5'd25;
            16'h9F5B: m.idx = 5'd26;
            16'h9F63: m.idx = 5'd27;
            16'h9F74: m.idx = 5'd28;
            default: begin
                m.known = 1'b0;
                m.idx   = 5'd0;
            end
        endcase
        return m;
    endfunction

    // Capacity of each field in value characters; unused indexes hold nothing.
    function automatic logic [CapW-1:0] field_cap(input logic [FieldW-1:0] idx);
        logic [CapW-1:0] cap;
        unique case (idx)
            5'd0:    cap = 8'd128;
            5'd1:    cap = 8'd128;
            5'd2:    cap = 8'd4;
            5'd3:    cap = 8'd32;
            5'd4:    cap = 8'd32;
            5'd5:    cap = 8'd10;
            5'd6:    cap = 8'd6;
            5'd7:    cap = 8'd2;
            5'd8:    cap = 8'd4;
            5'd9:    cap = 8'd12;
            5'd10:   cap = 8'd12;
            5'd11:   cap = 8'd32;
            5'd12:   cap = 8'd4;
            5'd13:   cap = 8'd4;
            5'd14:   cap = 8'd64;
            5'd15:   cap = 8'd4;
            5'd16:   cap = 8'd16;
            5'd17:   cap = 8'd16;
            5'd18:   cap = 8'd2;
            5'd19:   cap = 8'd6;
            5'd20:   cap = 8'd6;
            5'd21:   cap = 8'd2;
            5'd22:   cap = 8'd4;
            5'd23:   cap = 8'd8;
            5'd24:   cap = 8'd8;
            5'd25:   cap = 8'd2;
            5'd26:   cap = 8'd50;
            5'd27:   cap = 8'd32;
            5'd28:   cap = 8'd12;
            default: cap = 8'd0;
        endcase
        return cap;
    endfunction

endpackage

`default_nettype wire

### rtl/hex_tlv_tag_field_parser.sv
// Hex-text TLV tag field parser, top level: input word register, parser state,
// result register and stream handshakes. Depends on htlv_pkg and htlv_step.
//
// Usage:
//   The slave stream carries one ASCII character per word in s_tdata; s_tuser
//   marks the first character of a record and restarts parsing at a tag.
//   The master stream returns one word for each value character of a known
//   tag (field number, offset, capacity flag, m_tlast on the final character)
//   and one error word (m_tuser high) for a bad hex digit in a tag or length,
//   after which characters are dropped until the next record start.
//   Path: an accepted word is held in the input word register and parsed
//   from there; its result is loaded into the result register, unless a held
//   result stalls it, and is offered on m_tvalid from then on.
//   Throughput: one character per cycle; the character register and the
//   result register overlap, so a new character is taken every cycle while
//   the receiver keeps up.
//   Stall: while m_tready is low a held result blocks only characters that
//   would produce another result; characters without a result still advance.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to the start of a tag with no halt pending.
`default_nettype none

module hex_tlv_tag_field_parser (
    input  wire         aclk,
    input  wire         aresetn,
    // Input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] char_code
    input  wire  [0:0]  s_tuser,   // [0] record_start
    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // [4:0] field_id, [13:5] value_offset,
                                   // [21:14] value_char, [22] fits_field, [23] zero
    output logic [0:0]  m_tuser,   // [0] status
    output logic        m_tlast    // last_char
);

    // Input word register.
    logic                          stg_valid_reg;
    logic                          stg_valid_next;
    logic [htlv_pkg::CharW-1:0]    stg_char_reg;
    logic                          stg_start_reg;

    // Parser state and result register.
    htlv_pkg::parse_state_t        state_reg;
    htlv_pkg::parse_state_t        state_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    htlv_pkg::result_t             out_data_reg;

    logic                          step_emit;
    htlv_pkg::result_t             step_result;
    logic                          out_free;
    logic                          proceed;

    htlv_step u_step (
        .state_cur    (state_reg),
        .char_code    (stg_char_reg),
        .record_start (stg_start_reg),
        .state_nxt    (state_next),
        .emit         (step_emit),
        .result       (step_result)
    );

    // Handshake: the held word proceeds unless its result has nowhere to go.
    always_comb begin
        out_free       = !out_valid_reg || m_tready;
        proceed        = stg_valid_reg && (!step_emit || out_free);
        s_tready       = !stg_valid_reg || proceed;
        stg_valid_next = s_tready ? s_tvalid : stg_valid_reg;
        out_valid_next = out_free ? (stg_valid_reg && step_emit) : out_valid_reg;
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= htlv_pkg::StateReset;
        end else begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
            if (proceed) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            stg_char_reg  <= s_tdata;
            stg_start_reg <= s_tuser[0];
        end
        if (proceed && step_emit) begin
            out_data_reg <= step_result;
        end
    end

    // Result word packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg.fits_field, out_data_reg.value_char,
                       out_data_reg.value_offset, out_data_reg.field_id};
    assign m_tuser  = out_data_reg.status;
    assign m_tlast  = out_data_reg.last_char;

`ifndef SYNTHESIS
    // The value phase is never left with no characters to go.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == htlv_pkg::PH_VAL |-> state_reg.chars_left != '0)
        else $error("value phase entered with zero characters left");

    // An error result leaves the parser halted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && step_emit && step_result.status == htlv_pkg::ST_BADHEX
        |=> state_reg.halted)
        else $error("bad header digit did not halt the parser");

    // A halted parser without a record start produces nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid_reg && state_reg.halted && !stg_start_reg |-> !step_emit)
        else $error("halted parser produced a result");

    // Value results only carry a known field number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == htlv_pkg::ST_VALUE
        |-> m_tdata[4:0] < 5'(htlv_pkg::NumTags))
        else $error("value result with an out-of-range field number");
`endif

endmodule

`default_nettype wire

### rtl/htlv_step.sv
// Per-character step of the hex-text TLV parser: next parser state and the
// optional result word for one character. Pure combinational logic; uses htlv_pkg.
`default_nettype none

module htlv_step (
    input  var htlv_pkg::parse_state_t      state_cur,
    input  wire [htlv_pkg::CharW-1:0]       char_code,
    input  wire                             record_start,
    output htlv_pkg::parse_state_t          state_nxt,
    output logic                            emit,
    output htlv_pkg::result_t               result
);

    htlv_pkg::parse_state_t st;
    htlv_pkg::hex_t         hex;
    htlv_pkg::tag_match_t   match;
    logic [2:0]             digits_done;
    logic [htlv_pkg::OffsetW-1:0] left_dec;
    logic [htlv_pkg::TagW-1:0]    tag_shift;
    logic [htlv_pkg::LengthW-1:0] len_shift;

    // Decode and shifted header values used by the phase logic below.
    always_comb begin
        st          = record_start ? htlv_pkg::StateReset : state_cur;
        hex         = htlv_pkg::hex_decode(char_code);
        tag_shift   = {st.tag_value[htlv_pkg::TagW-5:0], hex.val};
        len_shift   = {st.length_value[htlv_pkg::LengthW-5:0], hex.val};
        match       = htlv_pkg::tag_lookup(tag_shift);
        digits_done = {1'b0, st.digit_count} + 3'd1;
        left_dec    = st.chars_left - htlv_pkg::OffsetW'(1);
    end

    // Phase sequencing: tag digits, length digits, then value characters.
    always_comb begin
        state_nxt           = st;
        emit                = 1'b0;
        result.status       = htlv_pkg::ST_VALUE;
        result.field_id     = st.current_field;
        result.value_offset = st.char_offset;
        result.value_char   = char_code;
        result.last_char    = (st.chars_left == htlv_pkg::OffsetW'(1));
        result.fits_field   = ({1'b0, st.char_offset} <
                               {2'b00, htlv_pkg::field_cap(st.current_field)});

        if (!st.halted) begin
            if (st.phase == htlv_pkg::PH_VAL && st.chars_left != '0) begin
                // Value character: pass through, emitted only for a known tag.
                emit                  = st.field_known;
                state_nxt.char_offset = st.char_offset + htlv_pkg::OffsetW'(1);
                state_nxt.chars_left  = left_dec;
                if (left_dec == '0) begin
                    state_nxt.phase       = htlv_pkg::PH_TAG;
                    state_nxt.digit_count = 2'd0;
                    state_nxt.tag_digits  = htlv_pkg::TagDigitsShort;
                    state_nxt.tag_value   = '0;
                end
            end else begin
                // A value phase with nothing left restarts at a fresh tag.
                if (st.phase == htlv_pkg::PH_VAL) begin
                    state_nxt.phase       = htlv_pkg::PH_TAG;
                    state_nxt.digit_count = 2'd0;
                    state_nxt.tag_digits  = htlv_pkg::TagDigitsShort;
                    state_nxt.tag_value   = '0;
                end
                if (!hex.ok) begin
                    // Bad header digit: report it and halt until a record start.
                    state_nxt.halted    = 1'b1;
                    emit                = 1'b1;
                    result.status       = htlv_pkg::ST_BADHEX;
                    result.field_id     = '0;
                    result.value_offset = '0;
                    result.last_char    = 1'b0;
                    result.fits_field   = 1'b0;
                end else if (st.phase == htlv_pkg::PH_LEN) begin
                    state_nxt.length_value = len_shift;
                    if (digits_done >= htlv_pkg::LengthDigits) begin
                        state_nxt.digit_count = 2'd0;
                        state_nxt.chars_left  = {len_shift, 1'b0};
                        state_nxt.char_offset = '0;
                        state_nxt.phase       = (len_shift == '0) ? htlv_pkg::PH_TAG
                                                                  : htlv_pkg::PH_VAL;
                        if (len_shift == '0) begin
                            state_nxt.tag_digits = htlv_pkg::TagDigitsShort;
                            state_nxt.tag_value  = '0;
                        end
                    end else begin
                        state_nxt.digit_count = digits_done[1:0];
                    end
                end else begin
                    // Tag digit (the value phase with nothing left lands here too).
                    state_nxt.phase     = htlv_pkg::PH_TAG;
                    state_nxt.tag_value = tag_shift;
                    if (st.digit_count == 2'd1 && char_code == htlv_pkg::CharUpperF) begin
                        state_nxt.tag_digits = htlv_pkg::TagDigitsLong;
                    end
                    if (digits_done >= state_nxt.tag_digits) begin
                        state_nxt.field_known   = match.known;
                        state_nxt.current_field = match.idx;
                        state_nxt.digit_count   = 2'd0;
                        state_nxt.length_value  = '0;
                        state_nxt.phase         = htlv_pkg::PH_LEN;
                    end else begin
                        state_nxt.digit_count = digits_done[1:0];
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_hex_tlv_tag_field_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for the hex-text TLV tag field parser: a scoreboard class predicts
// the result words character by character; tasks drive the input, an initial block the output.
// Depends on htlv_pkg and hex_tlv_tag_field_parser.

module tb_hex_tlv_tag_field_parser;

    localparam int CycleLimit = 400000;
    localparam int RandomChars = 450;

    // Tracks the parser state from the accepted characters and holds the result words
    // still owed by the block.
    class tlv_word_scoreboard;
        htlv_pkg::phase_t  ph;
        logic [1:0]        digits_seen;
        logic [2:0]        tag_len;
        logic [15:0]       tag_acc;
        logic [7:0]        len_acc;
        logic [8:0]        chars_left;
        logic [4:0]        field;
        bit                known;
        logic [8:0]        offset;
        bit                stopped;
        htlv_pkg::result_t pending_words[$];
        logic [15:0]       known_tags[htlv_pkg::NumTags];
        int                caps[htlv_pkg::NumTags];
        int                mismatches;
        int                words_checked;
        int                error_words;
        int                overflow_words;

        function new();
            known_tags = '{16'h0071, 16'h0072, 16'h0082, 16'h0084, 16'h0091, 16'h0095,
                           16'h009A, 16'h009C, 16'h5F2A, 16'h9F02, 16'h9F03, 16'h9F06,
                           16'h9F07, 16'h9F09, 16'h9F10, 16'h9F1A, 16'h9F1E, 16'h9F26,
                           16'h9F27, 16'h9F33, 16'h9F34, 16'h9F35, 16'h9F36, 16'h9F37,
                           16'h9F41, 16'h9F53, 16'h9F5B, 16'h9F63, 16'h9F74};
            caps = '{128, 128, 4, 32, 32, 10, 6, 2, 4, 12, 12, 32, 4, 4, 64, 4, 16,
                     16, 2, 6, 6, 2, 4, 8, 8, 2, 50, 32, 12};
            mismatches = 0;
            words_checked = 0;
            error_words = 0;
            overflow_words = 0;
            clear();
        endfunction

        function void restart_tag();
            ph = htlv_pkg::PH_TAG;
            digits_seen = 2'd0;
            tag_len = htlv_pkg::TagDigitsShort;
            tag_acc = '0;
        endfunction

        function void clear();
            restart_tag();
            len_acc = '0;
            chars_left = '0;
            field = '0;
            known = 1'b0;
            offset = '0;
            stopped = 1'b0;
        endfunction

        // Value of an ASCII hex digit in either case, or -1 for anything else.
        function int hex_nibble(input logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            return -1;
        endfunction

        // Advance the parser by one character; returns 1 when it yields a result word.
        function bit parse_char(input logic [7:0] c, input logic rs,
                                output htlv_pkg::result_t w);
            int nib;
            int n;
            bit hit;
            w = '0;
            if (rs) clear();
            if (stopped) return 1'b0;

            // Value characters pass through without a hex check.
            if (ph == htlv_pkg::PH_VAL) begin
                if (chars_left == 0) begin
                    restart_tag();
                end else begin
                    hit = known;
                    if (known) begin
                        w.status = htlv_pkg::ST_VALUE;
                        w.field_id = field;
                        w.value_offset = offset;
                        w.value_char = c;
                        w.last_char = (chars_left == 9'd1);
                        w.fits_field = (int'(offset) < caps[field]);
                    end
                    offset = offset + 9'd1;
                    chars_left = chars_left - 9'd1;
                    if (chars_left == 0) restart_tag();
                    return hit;
                end
            end

            // A bad header character reports once and halts until the next record start.
            nib = hex_nibble(c);
            if (nib < 0) begin
                stopped = 1'b1;
                w.status = htlv_pkg::ST_BADHEX;
                w.value_char = c;
                return 1'b1;
            end

            if (ph == htlv_pkg::PH_LEN) begin
                len_acc = {len_acc[3:0], 4'(nib)};
                n = digits_seen + 1;
                if (n >= 2) begin
                    digits_seen = 2'd0;
                    chars_left = {len_acc, 1'b0};
                    offset = '0;
                    if (chars_left == 0) restart_tag();
                    else ph = htlv_pkg::PH_VAL;
                end else begin
                    digits_seen = 2'(n);
                end
                return 1'b0;
            end

            // Tag characters; an uppercase F in second place asks for two more.
            ph = htlv_pkg::PH_TAG;
            tag_acc = {tag_acc[11:0], 4'(nib)};
            if (digits_seen == 2'd1 && c == htlv_pkg::CharUpperF) begin
                tag_len = htlv_pkg::TagDigitsLong;
            end
            n = digits_seen + 1;
            if (n >= int'(tag_len)) begin
                known = 1'b0;
                field = '0;
                for (int i = 0; i < htlv_pkg::NumTags; i++) begin
                    if (known_tags[i] == tag_acc) begin
                        known = 1'b1;
                        field = 5'(i);
                    end
                end
                digits_seen = 2'd0;
                len_acc = '0;
                ph = htlv_pkg::PH_LEN;
            end else begin
                digits_seen = 2'(n);
            end
            return 1'b0;
        endfunction

        function void note_char(input logic [7:0] c, input logic rs);
            htlv_pkg::result_t w;
            if (parse_char(c, rs, w)) pending_words.push_back(w);
        endfunction

        // Every mismatch prints one line and is counted.
        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_word(input logic [23:0] d, input logic st, input logic lst);
            htlv_pkg::result_t want;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word tdata=%h tuser=%b tlast=%b",
                                          d, st, lst));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (want.status == htlv_pkg::ST_BADHEX) error_words++;
            else if (!want.fits_field) overflow_words++;
            if (st !== want.status)
                report_mismatch($sformatf("word %0d status %b, want %b",
                                          words_checked, st, want.status));
            if (d[4:0] !== want.field_id)
                report_mismatch($sformatf("word %0d field_id %0d, want %0d",
                                          words_checked, d[4:0], want.field_id));
            if (d[13:5] !== want.value_offset)
                report_mismatch($sformatf("word %0d value_offset %0d, want %0d",
                                          words_checked, d[13:5], want.value_offset));
            if (d[21:14] !== want.value_char)
                report_mismatch($sformatf("word %0d value_char %h, want %h",
                                          words_checked, d[21:14], want.value_char));
            if (d[22] !== want.fits_field)
                report_mismatch($sformatf("word %0d fits_field %b, want %b",
                                          words_checked, d[22], want.fits_field));
            if (lst !== want.last_char)
                report_mismatch($sformatf("word %0d last_char %b, want %b",
                                          words_checked, lst, want.last_char));
            if (d[23] !== 1'b0)
                report_mismatch($sformatf("word %0d pad bit of tdata not zero", words_checked));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;    // [4:0] field_id, [13:5] value_offset, [21:14] value_char,
                             // [22] fits_field, [23] zero
    logic [0:0]  m_tuser;    // [0] status
    logic        m_tlast;

    tlv_word_scoreboard sb;
    int cycle_count = 0;
    int chars_sent = 0;
    int tx_gap_max = 7;
    int rx_gap_max = 7;
    bit record_flag = 1'b0;

    hex_tlv_tag_field_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle counter for the run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CycleLimit);
        $display("Run limit of %0d cycles reached.", CycleLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Send one character word; called and returns at a falling edge. A pending record
    // flag marks this character as the start of a record.
    task automatic send_char(input logic [7:0] c, input logic rs);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= rs | record_flag;
        record_flag = 1'b0;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_char(s_tdata, s_tuser[0]);
        chars_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string t, input bit rs);
        for (int i = 0; i < t.len(); i++) send_char(t[i], rs && i == 0);
    endtask

    function automatic logic [7:0] hex_text(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return 8'((upper ? 8'h41 : 8'h61) + nib - 10);
    endfunction

    // One TLV item: tag, length, then nvals value characters. With corrupt set, one
    // header character is swapped for a non-hex one.
    task automatic send_tlv(input logic [15:0] tag, input logic [7:0] len, input int nvals,
                            input bit corrupt);
        logic [7:0] hdr[6];
        int nh;
        int k;
        if (tag > 16'h00FF) begin
            hdr[0] = hex_text(tag[15:12], $urandom_range(0, 1));
            hdr[1] = htlv_pkg::CharUpperF;
            hdr[2] = hex_text(tag[7:4], $urandom_range(0, 1));
            hdr[3] = hex_text(tag[3:0], $urandom_range(0, 1));
            nh = 4;
        end else begin
            hdr[0] = hex_text(tag[7:4], $urandom_range(0, 1));
            hdr[1] = hex_text(tag[3:0], $urandom_range(0, 1));
            nh = 2;
        end
        hdr[nh] = hex_text(len[7:4], $urandom_range(0, 1));
        hdr[nh + 1] = hex_text(len[3:0], $urandom_range(0, 1));
        nh += 2;
        if (corrupt) begin
            k = $urandom_range(0, nh - 1);
            do hdr[k] = 8'($urandom_range(0, 255)); while (sb.hex_nibble(hdr[k]) >= 0);
        end
        for (int i = 0; i < nh; i++) send_char(hdr[i], 1'b0);
        repeat (nvals) send_char(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Mostly known tags with short values, some values past the field capacity,
    // some unknown tags, and now and then a value cut short.
    task automatic random_tlv(input bit cut);
        int pick;
        int cap;
        int len;
        int sel;
        int nvals;
        logic [15:0] tag;
        pick = $urandom_range(0, htlv_pkg::NumTags + 5);
        if (pick < htlv_pkg::NumTags) begin
            tag = sb.known_tags[pick];
            cap = sb.caps[pick];
        end else begin
            cap = 8;
            if ($urandom_range(0, 1)) tag = {8'h00, 8'($urandom_range(0, 255))};
            else tag = {4'($urandom_range(0, 15)), 4'hF, 8'($urandom_range(0, 255))};
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) len = 0;
        else if (sel <= 6) len = $urandom_range(1, 4);
        else len = cap / 2 + $urandom_range(0, 3);
        nvals = 2 * len;
        if (cut) nvals = $urandom_range(0, nvals);
        send_tlv(tag, 8'(len), nvals, $urandom_range(0, 24) == 0);
    endtask

    // A record of items (now and then with a bad header character), a truncated record, or plain noise.
    task automatic random_record();
        int kind;
        int items;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        record_flag = ($urandom_range(0, 3) != 0);
        if (kind == 0) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 1)) c = 8'($urandom_range(0, 255));
                else c = hex_text(4'($urandom_range(0, 15)), $urandom_range(0, 1));
                send_char(c, $urandom_range(0, 7) == 0);
            end
        end else begin
            items = $urandom_range(1, 4);
            for (int i = 0; i < items; i++) random_tlv(kind == 1 && i == items - 1);
        end
    endtask

    // Result side: a random stall before each word, then wait for it.
    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_word(m_tdata, m_tuser[0], m_tlast);
            @(negedge aclk);
        end
    end

    initial begin
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: a short known tag in lowercase with extreme value bytes running past
        // its capacity, a long known tag with zero length, an unknown tag with a value,
        // a bad length character, a character dropped while halted, and a record start
        // that clears the halt and is itself abandoned by the next record.
        send_text("9c02", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("Az9F07001201xy84", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("Q", 1'b0);
        send_text("9f", 1'b1);

        while (chars_sent < RandomChars + 26) random_record();

        // One maximum length value: offsets run up to 509, near the top of their 9-bit range.
        tx_gap_max = 2;
        rx_gap_max = 2;
        record_flag = 1'b1;
        send_tlv(16'h0071, 8'hFF, 510, 1'b0);
        s_tvalid <= 1'b0;

        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d characters; checked %0d result words, %0d of them header errors",
                 chars_sent, sb.words_checked, sb.error_words);
        $display("and %0d past their field capacity; %0d mismatches.",
                 sb.overflow_words, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/htlv_pkg.sv
rtl/htlv_step.sv
rtl/hex_tlv_tag_field_parser.sv
tb/sv/tb_hex_tlv_tag_field_parser.sv
